[design/assert_macros.svh]
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[design/pcm_conv_pkg.sv]
// ----------------------------------------------------------------------------
// PCM converter package
// Format codes, the float32 scale factor and the byte count per format.
// ----------------------------------------------------------------------------
package pcm_conv_pkg;

  localparam logic [2:0] FMT_PCM16   = 3'd0;
  localparam logic [2:0] FMT_PCM8    = 3'd1;
  localparam logic [2:0] FMT_PCM24   = 3'd2;
  localparam logic [2:0] FMT_PCM32   = 3'd3;
  localparam logic [2:0] FMT_FLOAT32 = 3'd4;

  // Multiplier 32767 as an integer, leading one at bit 14
  localparam logic [15:0] SCALE = 16'd32767;

  // Bytes needed minus one for a format code
  function automatic logic [1:0] last_index(input logic [2:0] fmt);
    logic [1:0] r;
    begin
      unique case (fmt)
        FMT_PCM8:    r = 2'd0;
        FMT_PCM24:   r = 2'd2;
        FMT_PCM32:   r = 2'd3;
        FMT_FLOAT32: r = 2'd3;
        default:     r = 2'd1;
      endcase
      return r;
    end
  endfunction

endpackage

[design/pcm_sample_to_int16_converter.sv]
// A result appears in the cycle after the input byte that completes it.
// One byte per cycle unless stalled; the float multiply follows the result register.
// Reset (rst, synchronous): format pcm16, no bytes held, output empty.
// A configuration write drops any partially gathered sample and stalls input.
// ----------------------------------------------------------------------------
// PCM sample to int16 converter
// Gathers little-endian sample bytes and converts each sample to int16.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcm_sample_to_int16_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] data_byte
  input  logic        s_tlast,       // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // [15:0] sample_out
  output logic        m_tlast,       // is_last
  output logic        m_tuser        // misaligned
);

  logic [2:0]  sample_format;
  logic [1:0]  byte_count;
  logic [23:0] byte_hold;
  logic        in_fire, done, emit;
  logic [31:0] word;
  logic [15:0] int_val;
  logic        is_float;
  logic [23:0] mant;
  logic [7:0]  expo;
  logic        sgn;
  logic [39:0] prod;
  logic        out_ok;

  assign cfg_ready = 1'b1;
  assign s_tready  = (!m_tvalid || m_tready) && !cfg_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign done      = byte_count >= pcm_conv_pkg::last_index(sample_format);
  assign emit      = in_fire && (done || s_tlast);
  assign word      = {s_tdata, byte_hold};

  // Select the integer result and unpack the float operand
  always_comb begin
    int_val = {s_tdata, byte_hold[7:0]};
    unique case (sample_format)
      pcm_conv_pkg::FMT_PCM8:  int_val = {s_tdata ^ 8'h80, 8'h00};
      pcm_conv_pkg::FMT_PCM24: int_val = {s_tdata, byte_hold[15:8]};
      pcm_conv_pkg::FMT_PCM32: int_val = {s_tdata, byte_hold[23:16]};
      default:                 int_val = {s_tdata, byte_hold[7:0]};
    endcase
    sgn  = word[31];
    expo = word[30:23];
    mant = {1'b1, word[22:0]};
    // Clamp: NaN to +1, magnitude >= 1 to 1, denormals flush (result 0)
    if (expo == 8'hFF && word[22:0] != 23'd0) begin
      sgn = 1'b0; expo = 8'd127; mant = 24'h800000;
    end else if (expo >= 8'd127) begin
      expo = 8'd127; mant = 24'h800000;
    end else if (expo == 8'd0) begin
      mant = 24'd0;
    end
  end

  // Stage registers for the float path
  logic        f_sgn;
  logic [7:0]  f_expo;
  logic [23:0] f_mant;
  logic [15:0] r_int;
  logic        r_float, r_mis, r_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= pcm_conv_pkg::FMT_PCM16;
      byte_count <= '0;
      byte_hold <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= emit || (m_tvalid && !m_tready);
      if (cfg_valid) begin
        sample_format <= cfg_data;
        byte_count <= '0;
        byte_hold <= '0;
      end else if (in_fire) begin
        if (emit) begin
          byte_count <= '0;
          byte_hold <= '0;
        end else begin
          unique case (byte_count)
            2'd0: byte_hold[7:0] <= s_tdata;
            2'd1: byte_hold[15:8] <= s_tdata;
            default: byte_hold[23:16] <= s_tdata;
          endcase
          byte_count <= byte_count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      r_mis   <= !done;
      r_last  <= s_tlast;
      r_int   <= done ? int_val : 16'd0;
      r_float <= done && sample_format == pcm_conv_pkg::FMT_FLOAT32;
      f_sgn   <= sgn;
      f_expo  <= expo;
      f_mant  <= mant;
    end
  end

  // Multiply, round the product to 24 bits (nearest even), then truncate
  logic [5:0]  lz;
  logic [39:0] pn;
  logic [24:0] rm;
  logic [8:0]  sh;
  logic [47:0] fx;
  logic [15:0] mag;
  logic        rb, st;
  always_comb begin
    prod = f_mant * pcm_conv_pkg::SCALE;
    // product has bit 38 or 37 as leading one
    if (prod[38]) begin
      pn = prod; lz = 6'd0;
    end else begin
      pn = prod << 1; lz = 6'd1;
    end
    rb = pn[14];
    st = pn[13:0] != 14'd0;
    rm = {1'b0, pn[38:15]} + {24'd0, rb && (st || pn[15])};
    // value = rm * 2^(expo-127+14+1-lz-23)
    fx  = {23'd0, rm} << 23;
    sh  = 9'd127 + 9'd23 + {3'd0, lz} - 9'd15 - {1'b0, f_expo};
    fx  = fx >> sh;
    mag = fx[38:23];
    if (f_mant == 24'd0) mag = 16'd0;
    is_float = r_float;
  end

  assign m_tdata = is_float ? (f_sgn ? 16'd0 - mag : mag) : r_int;
  assign m_tlast = r_last;
  assign m_tuser = r_mis;
  assign out_ok  = !m_tuser || (m_tdata == 16'd0 && m_tlast);

  `ASSERT_IMPLY(a_mis_zero, clk, rst, m_tvalid, out_ok)
  `ASSERT_NEXT(a_emit_valid, clk, rst, emit, m_tvalid)
  `ASSERT_NEXT(a_emit_clear, clk, rst, emit && !cfg_valid, byte_count == 2'd0)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// PCM sample to int16 converter testbench
// Streams sample bytes through every format setting and checks each sample
// transaction against a predictor of the byte gathering and conversion.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        misaligned;
  } sample_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;        // [7:0] data_byte
  logic        s_tlast;        // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;        // [15:0] sample_out
  logic        m_tlast;        // is_last
  logic        m_tuser;        // misaligned

  byte_item_t   pending_bytes[$];
  sample_item_t expected_samples[$];
  logic [2:0]   cur_format;
  logic [1:0]   held_count;
  logic [23:0]  held_bytes;
  int           cycle_count = 0;
  int           error_count = 0;
  bit           quiet = 1'b0;

  pcm_sample_to_int16_converter DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Float32 clamped, scaled by 32767 in single precision, truncated to zero
  function automatic logic [15:0] float_scaled(input logic [31:0] f);
    int     e;
    int     nb;
    int     sh;
    longint m;
    longint p;
    longint q;
    longint rem;
    longint half;
    longint ip;
    e = int'(f[30:23]);
    if (e == 255 && f[22:0] != 0) return 16'sd32767;
    if (e >= 127) return f[31] ? -16'sd32767 : 16'sd32767;
    if (e == 0) begin
      m = longint'(f[22:0]);
      e = 1;
    end else begin
      m = longint'({1'b1, f[22:0]});
    end
    p = m * 32767;
    if (p == 0) return 16'd0;
    nb = 0;
    while ((p >> nb) != 0) nb++;
    // Round the product to 24 significant bits, ties to even
    if (nb > 24) begin
      sh = nb - 24;
      q = p >> sh;
      rem = p & ((longint'(1) << sh) - 1);
      half = longint'(1) << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      p = q << sh;
    end
    if (150 - e >= 63) ip = 0;
    else ip = p >> (150 - e);
    if (f[31]) ip = -ip;
    return ip[15:0];
  endfunction

  // Advance the gathering state by one byte and queue any finished sample
  task automatic gather_byte(input byte_item_t it);
    int           need;
    sample_item_t r;
    case (cur_format)
      pcm_conv_pkg::FMT_PCM8:    need = 1;
      pcm_conv_pkg::FMT_PCM24:   need = 3;
      pcm_conv_pkg::FMT_PCM32:   need = 4;
      pcm_conv_pkg::FMT_FLOAT32: need = 4;
      default:                   need = 2;
    endcase
    if (int'(held_count) + 1 >= need) begin
      case (cur_format)
        pcm_conv_pkg::FMT_PCM8:    r.sample = {it.data - 8'd128, 8'd0};
        pcm_conv_pkg::FMT_PCM24:   r.sample = {it.data, held_bytes[15:8]};
        pcm_conv_pkg::FMT_PCM32:   r.sample = {it.data, held_bytes[23:16]};
        pcm_conv_pkg::FMT_FLOAT32: r.sample = float_scaled({it.data, held_bytes});
        default:                   r.sample = {it.data, held_bytes[7:0]};
      endcase
      r.last = it.last;
      r.misaligned = 1'b0;
      expected_samples.push_back(r);
      held_count = 2'd0;
      held_bytes = 24'd0;
    end else if (it.last) begin
      r.sample = 16'd0;
      r.last = 1'b1;
      r.misaligned = 1'b1;
      expected_samples.push_back(r);
      held_count = 2'd0;
      held_bytes = 24'd0;
    end else begin
      held_bytes = held_bytes | (24'(it.data) << (8 * held_count));
      held_count = held_count + 2'd1;
    end
  endtask

  // Drive byte transactions from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      held_count = 2'd0;
      held_bytes = 24'd0;
    end else begin
      // Drop the partial sample on a format write
      if (cfg_valid && cfg_ready) begin
        held_count = 2'd0;
        held_bytes = 24'd0;
      end
      if (s_tvalid && s_tready) gather_byte('{s_tdata, s_tlast});
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
          s_tvalid <= 1'b1;
          {s_tdata, s_tlast} <= pending_bytes.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check sample transactions and stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, actual %h last %b mis %b",
                   $time, m_tdata, m_tlast, m_tuser);
          error_count++;
        end else begin
          sample_item_t e;
          e = expected_samples.pop_front();
          if (m_tdata !== e.sample)
            $display("%0t: sample expected %h actual %h", $time, e.sample, m_tdata);
          if (m_tlast !== e.last)
            $display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
          if (m_tuser !== e.misaligned)
            $display("%0t: misaligned expected %b actual %b", $time, e.misaligned, m_tuser);
          if (m_tdata !== e.sample || m_tlast !== e.last || m_tuser !== e.misaligned)
            error_count++;
        end
      end
      m_tready <= quiet || $urandom_range(99) >= 13;
    end
  end

  // Watchdog and the idle-free stretch
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    quiet <= cycle_count > 300 && cycle_count < 600;
    if (cycle_count > 300000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic l);
    pending_bytes.push_back('{b, l});
  endtask

  task automatic add_sample(input int nbytes, input logic [31:0] v, input logic l);
    for (int i = 0; i < nbytes; i++) add_byte(v[8*i +: 8], l && i == nbytes - 1);
  endtask

  // Hold until all bytes are taken and every sample has arrived
  task automatic drain();
    while (pending_bytes.size() > 0 || s_tvalid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input logic [2:0] f);
    cfg_valid <= 1'b1;
    cfg_data <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_format = f;
    cfg_valid <= 1'b0;
  endtask

  function automatic int width_of(input logic [2:0] f);
    case (f)
      pcm_conv_pkg::FMT_PCM8:    return 1;
      pcm_conv_pkg::FMT_PCM24:   return 3;
      pcm_conv_pkg::FMT_PCM32:   return 4;
      pcm_conv_pkg::FMT_FLOAT32: return 4;
      default:                   return 2;
    endcase
  endfunction

  // Random runs of well-formed samples, some ending mid-sample
  task automatic random_phase(input int nbytes);
    int w;
    int n;
    logic [31:0] v;
    w = width_of(cur_format);
    n = 0;
    while (n < nbytes) begin
      v = $urandom;
      if (cur_format == pcm_conv_pkg::FMT_FLOAT32 && $urandom_range(3) != 0)
        v[30:23] = 8'($urandom_range(127, 100));
      if ($urandom_range(15) == 0) begin
        add_sample($urandom_range(w - 1, 1), v, 1'b1);
        n += w;
      end else begin
        add_sample(w, v, $urandom_range(9) == 0);
        n += w;
      end
    end
  endtask

  initial begin
    logic [2:0] order[10];
    order = '{pcm_conv_pkg::FMT_PCM16, pcm_conv_pkg::FMT_PCM8, pcm_conv_pkg::FMT_PCM24,
              pcm_conv_pkg::FMT_PCM32, pcm_conv_pkg::FMT_FLOAT32,
              3'd5, 3'd6, 3'd7, pcm_conv_pkg::FMT_FLOAT32, pcm_conv_pkg::FMT_PCM8};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 3'd0;
    cur_format = pcm_conv_pkg::FMT_PCM16;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pcm16 extremes and a mid-sample end, then pcm8, float32 and pcm24 cases
    add_sample(2, 32'h8000, 1'b0);
    add_sample(2, 32'h7fff, 1'b0);
    add_byte(8'hff, 1'b1);
    drain();
    write_format(pcm_conv_pkg::FMT_PCM8);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h80, 1'b1);
    drain();
    write_format(pcm_conv_pkg::FMT_FLOAT32);
    add_sample(4, 32'h3f800000, 1'b0);
    add_sample(4, 32'hbf800000, 1'b0);
    add_sample(4, 32'h7fc00000, 1'b0);
    add_sample(4, 32'hff800000, 1'b0);
    add_sample(4, 32'h3f000000, 1'b0);
    add_sample(4, 32'h80000001, 1'b1);
    // Leave a partial sample for the next write to drop
    add_sample(3, 32'h00ffffff, 1'b0);
    drain();
    write_format(pcm_conv_pkg::FMT_PCM24);
    add_sample(3, 32'h00ffffff, 1'b1);
    drain();

    // Random phases through every format code
    foreach (order[i]) begin
      write_format(order[i]);
      random_phase(75);
      drain();
    end

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
